/* src/crf_pkg.sv */
// Shared types and constants for the clipped rectangle fill engine.
`default_nettype none

package crf_pkg;

    localparam int PIXEL_BITS  = 32;
    localparam int COORD_W     = 12;
    localparam int SCREEN_W    = 9;
    localparam int COUNT_W     = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int MAC_W       = 24;

    localparam logic [PIXEL_BITS-1:0] BORDER_GRAY = 32'hff666666;

    localparam logic REQ_FILL = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SCREEN_W-1:0] SCREEN_RESET = 9'd256;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    typedef struct packed {
        logic                  req_type;
        logic                  border_enable;
        logic [COORD_W-1:0]    x_pos;
        logic [COORD_W-1:0]    y_pos;
        logic [COORD_W-1:0]    rect_width;
        logic [COORD_W-1:0]    rect_height;
        logic [COORD_W-1:0]    clip_x_min;
        logic [COORD_W-1:0]    clip_x_max;
        logic [COORD_W-1:0]    clip_y_min;
        logic [COORD_W-1:0]    clip_y_max;
        logic [PIXEL_BITS-1:0] fill_color;
    } crf_req_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] read_color;
        logic [COUNT_W-1:0]    pixels_written;
    } crf_result_t;

    typedef struct packed {
        logic load;
        logic clip_a;
        logic clip_b;
        logic clip_c;
        logic setup;
        logic addr_init;
        logic write_step;
        logic read_issue;
        logic read_capture;
    } crf_cmd_t;

    typedef struct packed {
        logic is_read;
        logic span_empty;
        logic last_col;
        logic last_row;
    } crf_status_t;

endpackage

`default_nettype wire

/* src/crf_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none

module crf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/crf_ctrl.sv */
// Sequencer for the fill engine: steps clip, setup, fill and read phases.
`default_nettype none

module crf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire crf_pkg::crf_status_t status,
    output crf_pkg::crf_cmd_t         cmd,
    output logic                      busy,
    output logic                      done
);

    import crf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLIP_A = 4'd1;
    localparam logic [3:0] S_CLIP_B = 4'd2;
    localparam logic [3:0] S_CLIP_C = 4'd3;
    localparam logic [3:0] S_SETUP  = 4'd4;
    localparam logic [3:0] S_ADDR   = 4'd5;
    localparam logic [3:0] S_FILL   = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_RWAIT  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLIP_A;
                end
            end
            S_CLIP_A:
            begin
                cmd.clip_a = 1'b1;
                state_next = S_CLIP_B;
            end
            S_CLIP_B:
            begin
                cmd.clip_b = 1'b1;
                state_next = S_CLIP_C;
            end
            S_CLIP_C:
            begin
                cmd.clip_c = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr_init = 1'b1;
                state_next    = status.is_read ? S_READ : S_FILL;
            end
            S_FILL:
            begin
                if (status.span_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.write_step = 1'b1;
                    if (status.last_col && status.last_row)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = S_RWAIT;
            end
            S_RWAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CLIP_A))
        else $error("accepted request did not enter clipping");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("engine stayed busy after result");

    a_no_empty_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_step |-> !status.span_empty)
        else $error("pixel write issued for empty clip area");

endmodule

`default_nettype wire

/* src/crf_datapath.sv */
// Clip arithmetic, raster walk counters, config registers and frame store.
`default_nettype none

module crf_datapath #(
    parameter int STORE_WIDTH  = 256,
    parameter int STORE_HEIGHT = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire crf_pkg::crf_req_t                   req,
    input  wire crf_pkg::crf_cmd_t                   cmd,
    input  wire logic                                cfg_valid,
    input  wire logic [crf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [crf_pkg::SCREEN_W-1:0]        cfg_data,
    output crf_pkg::crf_status_t                     status,
    output crf_pkg::crf_result_t                     result
);

    import crf_pkg::*;

    localparam int DEPTH  = STORE_WIDTH * STORE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAD_W  = COORD_W - SCREEN_W;

    localparam logic [MAC_W-1:0]   STORE_W_M = MAC_W'(STORE_WIDTH);
    localparam logic [COORD_W-1:0] STORE_W_C = COORD_W'(STORE_WIDTH);
    localparam logic [COORD_W-1:0] STORE_H_C = COORD_W'(STORE_HEIGHT);
    localparam logic [ADDR_W:0]    DEPTH_C   = (ADDR_W+1)'(DEPTH);

    // screen size registers
    logic [SCREEN_W-1:0] cfg_w_reg;
    logic [SCREEN_W-1:0] cfg_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= SCREEN_RESET;
            cfg_h_reg <= SCREEN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  cfg_w_reg <= cfg_data;
                CFG_SCREEN_HEIGHT: cfg_h_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    logic [SCREEN_W-1:0] sw_act;
    logic [SCREEN_W-1:0] sh_act;
    logic [COORD_W-1:0]  sw_ext;
    logic [COORD_W-1:0]  sh_ext;

    assign sw_act = ({{PAD_W{1'b0}}, cfg_w_reg} > STORE_W_C) ? STORE_W_C[SCREEN_W-1:0]
                                                             : cfg_w_reg;
    assign sh_act = ({{PAD_W{1'b0}}, cfg_h_reg} > STORE_H_C) ? STORE_H_C[SCREEN_W-1:0]
                                                             : cfg_h_reg;
    assign sw_ext = {{PAD_W{1'b0}}, sw_act};
    assign sh_ext = {{PAD_W{1'b0}}, sh_act};

    // request and clip pipeline
    crf_req_t            req_reg;
    logic [COORD_W-1:0]  x0_reg, y0_reg;
    logic [SCREEN_W-1:0] xmax_reg, ymax_reg;
    logic [COORD_W:0]    xend_reg, yend_reg;
    logic                in_screen_reg;
    logic [SCREEN_W-1:0] x1_reg, y1_reg;
    logic [SCREEN_W-1:0] span_w_reg, span_h_reg;
    logic [SCREEN_W-1:0] xlast_reg, ylast_reg;
    logic                empty_reg;
    logic [MAC_W-1:0]    row_base_reg;
    logic [ADDR_W-1:0]   row_step_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [SCREEN_W-1:0] x_reg, y_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [PIXEL_BITS-1:0] read_color_reg;

    logic                  is_read;
    logic                  x_ne, y_ne;
    logic [2*SCREEN_W-1:0] prod_count;
    logic [COUNT_W-1:0]    count_sat;
    logic [COORD_W-1:0]    ycoord, xcoord;
    logic [MAC_W-1:0]      row_base_next;
    logic [MAC_W-1:0]      addr_sum;
    logic                  last_col, last_row;
    logic [SCREEN_W-1:0]   x_next, y_next;
    logic [ADDR_W-1:0]     addr_next;
    logic [PIXEL_BITS-1:0] pix;
    logic [PIXEL_BITS-1:0] rdata;
    logic                  ram_en;

    assign is_read  = (req_reg.req_type == REQ_READ);
    assign x_ne     = {{PAD_W{1'b0}}, x1_reg} > x0_reg;
    assign y_ne     = {{PAD_W{1'b0}}, y1_reg} > y0_reg;

    assign prod_count = span_w_reg * span_h_reg;
    assign count_sat  = (|prod_count[2*SCREEN_W-1:COUNT_W]) ? COUNT_MAX
                                                            : prod_count[COUNT_W-1:0];

    assign ycoord        = is_read ? req_reg.y_pos : y0_reg;
    assign xcoord        = is_read ? req_reg.x_pos : x0_reg;
    assign row_base_next = MAC_W'(ycoord) * STORE_W_M;
    assign addr_sum      = row_base_reg + MAC_W'(xcoord);

    assign last_col  = (x_reg == xlast_reg);
    assign last_row  = (y_reg == ylast_reg);
    assign x_next    = last_col ? x0_reg[SCREEN_W-1:0] : x_reg + 1'b1;
    assign y_next    = last_col ? y_reg + 1'b1 : y_reg;
    assign addr_next = addr_reg + (last_col ? row_step_reg : ADDR_W'(1));
    assign pix       = (req_reg.border_enable && (last_col || last_row)) ? BORDER_GRAY
                                                                        : req_reg.fill_color;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg        <= req;
            read_color_reg <= '0;
        end
        if (cmd.clip_a)
        begin
            x0_reg   <= (req_reg.x_pos < req_reg.clip_x_min) ? req_reg.clip_x_min
                                                              : req_reg.x_pos;
            y0_reg   <= (req_reg.y_pos < req_reg.clip_y_min) ? req_reg.clip_y_min
                                                              : req_reg.y_pos;
            xmax_reg <= (req_reg.clip_x_max > sw_ext) ? sw_act
                                                      : req_reg.clip_x_max[SCREEN_W-1:0];
            ymax_reg <= (req_reg.clip_y_max > sh_ext) ? sh_act
                                                      : req_reg.clip_y_max[SCREEN_W-1:0];
            xend_reg <= {1'b0, req_reg.x_pos} + {1'b0, req_reg.rect_width};
            yend_reg <= {1'b0, req_reg.y_pos} + {1'b0, req_reg.rect_height};
            in_screen_reg <= (req_reg.x_pos < sw_ext) && (req_reg.y_pos < sh_ext);
        end
        if (cmd.clip_b)
        begin
            x1_reg <= (xend_reg > {{(PAD_W+1){1'b0}}, xmax_reg}) ? xmax_reg
                                                                 : xend_reg[SCREEN_W-1:0];
            y1_reg <= (yend_reg > {{(PAD_W+1){1'b0}}, ymax_reg}) ? ymax_reg
                                                                 : yend_reg[SCREEN_W-1:0];
        end
        if (cmd.clip_c)
        begin
            span_w_reg <= x_ne ? x1_reg - x0_reg[SCREEN_W-1:0] : '0;
            span_h_reg <= y_ne ? y1_reg - y0_reg[SCREEN_W-1:0] : '0;
            xlast_reg  <= x1_reg - 1'b1;
            ylast_reg  <= y1_reg - 1'b1;
            empty_reg  <= !(x_ne && y_ne);
        end
        if (cmd.setup)
        begin
            row_base_reg <= row_base_next;
            row_step_reg <= ADDR_W'(STORE_W_M - MAC_W'(span_w_reg) + MAC_W'(1));
            count_reg    <= is_read ? '0 : count_sat;
            x_reg        <= x0_reg[SCREEN_W-1:0];
            y_reg        <= y0_reg[SCREEN_W-1:0];
        end
        if (cmd.addr_init)
        begin
            addr_reg <= addr_sum[ADDR_W-1:0];
        end
        if (cmd.write_step)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            addr_reg <= addr_next;
        end
        if (cmd.read_capture)
        begin
            read_color_reg <= in_screen_reg ? rdata : '0;
        end
    end

    assign ram_en = cmd.write_step || (cmd.read_issue && in_screen_reg);

    crf_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (cmd.write_step),
        .addr  (addr_reg),
        .wdata (pix),
        .rdata (rdata)
    );

    assign status.is_read    = is_read;
    assign status.span_empty = empty_reg;
    assign status.last_col   = last_col;
    assign status.last_row   = last_row;

    assign result.read_color     = read_color_reg;
    assign result.pixels_written = count_reg;

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_step |-> ({1'b0, addr_reg} < DEPTH_C))
        else $error("fill address outside frame store");

    a_walk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_step |-> ((x_reg <= xlast_reg) && (y_reg <= ylast_reg)))
        else $error("raster walk left the clipped area");

endmodule

`default_nettype wire

/* src/clipped_rectangle_fill_top.sv */
// Top level of the clipped rectangle fill engine.
`default_nettype none

// Clipped rectangle fill engine over a STORE_WIDTH x STORE_HEIGHT ARGB frame store.
//
// Request channel: a request (fill or pixel read) is taken on a rising edge with
//   start high and busy low. busy stays high until the result has been shown.
// Result channel: done pulses for exactly one cycle with result valid in that
//   cycle. There is no backpressure; the receiver must take it then.
// Config channel: cfg_valid/cfg_ready write screen_width (index 0) or
//   screen_height (index 1). cfg_ready is always high; write only when idle.
//   Other indexes are ignored.
// Sequence: a fill runs clip (steps A, B and C), setup, address, then one pixel per
//   cycle over the clipped area, then the result; an empty area writes no pixel.
//   A read runs clip, setup, address, read issue and read capture, then the result.
//   The sequencer passes through idle before the next request is taken.
// Throughput is set by the frame store's single port: one pixel per cycle.
// Reset: screen size returns to 256 x 256 and the sequencer goes idle; the
//   frame store is not cleared and holds garbage until written.
`default_nettype none

module clipped_rectangle_fill_top #(
    parameter int STORE_WIDTH  = 256,
    parameter int STORE_HEIGHT = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire crf_pkg::crf_req_t                req,
    // result channel
    output logic                                  done,
    output crf_pkg::crf_result_t                  result,
    // configuration channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [crf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [crf_pkg::SCREEN_W-1:0]     cfg_data
);

    import crf_pkg::*;

    crf_cmd_t    cmd;
    crf_status_t status;

    // registers must only be changed between requests; the block does not enforce it, and cfg_ready never holds off
    assign cfg_ready = 1'b1;

    // sequencer: owns the request handshake and result strobe
    crf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // clip math, raster walk and the frame store itself
    crf_datapath #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result)
    );

    // a result carries either a color (read) or a count (fill), never both
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.read_color == '0) || (result.pixels_written == '0)))
        else $error("result carries both color and count");

endmodule

`default_nettype wire

/* sim/clipped_rectangle_fill_top_tb.sv */
// Self-checking testbench for the clipped rectangle fill engine.
module clipped_rectangle_fill_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import crf_pkg::*;

    // Store geometry must match the instance below.
    localparam int STORE_W = 256;
    localparam int STORE_H = 256;

    // Index that the block decodes as no register; writing it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd2;

    // Random phases: screen sizes, RANDOM_SIZE picks a fresh 9-bit value.
    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 45;
    localparam int unsigned RANDOM_SIZE     = 1000;

    // The limit covers the directed part, which holds three full-screen fills, and
    // the random part. Everything else is margin.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    // Cycles allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [0:0] {
        ROW_REQ,
        ROW_CFG
    } row_kind_e;

    // One line of the directed table: a request (with an optional typed-in
    // answer) or a register write.
    typedef struct packed {
        row_kind_e               kind;
        logic                    typed;
        crf_req_t                rq;
        crf_result_t             want;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [SCREEN_W-1:0]     reg_value;
    } stim_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    crf_req_t                req       = '0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [SCREEN_W-1:0]     cfg_data  = '0;
    logic                    busy;
    logic                    done;
    crf_result_t             result;
    logic                    cfg_ready;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    clipped_rectangle_fill_top #(
        .STORE_WIDTH  (STORE_W),
        .STORE_HEIGHT (STORE_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: frame store contents and the two screen registers.
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] shadow_frame [STORE_W*STORE_H];
    logic [SCREEN_W-1:0]   scr_w = SCREEN_RESET;
    logic [SCREEN_W-1:0]   scr_h = SCREEN_RESET;

    // Answers still owed by the block, oldest first.
    crf_result_t pending_results [$];

    stim_row_t   stim_rows [$];
    int unsigned error_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned cycle_count   = 0;

    // Sender pacing: gap before the next request, and whether start is high.
    int unsigned pending_gap = 0;
    bit          start_held  = 1'b0;
    bit          no_idle     = 1'b0;

    function automatic int unsigned lim(input int unsigned v, input int unsigned top);
        return (v > top) ? top : v;
    endfunction

    function automatic logic [COORD_W-1:0] rand12();
        logic [31:0] t;
        t = $urandom();
        return t[COORD_W-1:0];
    endfunction

    // Predicts one request's answer and applies its writes to the shadow store.
    function automatic crf_result_t model_request(input crf_req_t r);
        crf_result_t           res;
        int unsigned           aw, ah, xp, yp, x_end, y_end, x0, y0, x1, y1, cnt;
        logic [PIXEL_BITS-1:0] v;
        res = '0;
        aw = lim(32'(scr_w), STORE_W);
        ah = lim(32'(scr_h), STORE_H);
        xp = 32'(r.x_pos);
        yp = 32'(r.y_pos);
        if (r.req_type == REQ_READ)
        begin
            // Outside the active screen the answer is zero.
            if (xp < aw && yp < ah)
                res.read_color = shadow_frame[yp * STORE_W + xp];
        end
        else
        begin
            // Window first limited to the screen, then the rectangle to the window.
            x_end = lim(32'(r.clip_x_max), aw);
            y_end = lim(32'(r.clip_y_max), ah);
            x0 = (xp < r.clip_x_min) ? int'(r.clip_x_min) : xp;
            y0 = (yp < r.clip_y_min) ? int'(r.clip_y_min) : yp;
            x1 = lim(xp + int'(r.rect_width), x_end);
            y1 = lim(yp + int'(r.rect_height), y_end);
            if (x1 < x0)
                x1 = x0;
            if (y1 < y0)
                y1 = y0;
            for (int unsigned y = y0; y < y1; y++)
            begin
                for (int unsigned x = x0; x < x1; x++)
                begin
                    v = r.fill_color;
                    if (r.border_enable && (y == y1 - 1 || x == x1 - 1))
                        v = BORDER_GRAY;
                    shadow_frame[y * STORE_W + x] = v;
                end
            end
            cnt = (x1 - x0) * (y1 - y0);
            if (cnt > COUNT_MAX)
                cnt = COUNT_MAX;
            res.pixels_written = COUNT_W'(cnt);
        end
        return res;
    endfunction

    task automatic log_error(input string msg);
        $display("ERROR @%0t result #%0d: %s", $realtime, results_seen, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker. done and result are sampled at the edge that ends the
    // strobe cycle, before the block's own updates at that edge land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        crf_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                log_error($sformatf("unexpected result: color %h count %0d",
                                    result.read_color, result.pixels_written));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.read_color !== want.read_color)
                    log_error($sformatf("read_color %h, expected %h",
                                        result.read_color, want.read_color));
                if (result.pixels_written !== want.pixels_written)
                    log_error($sformatf("pixels_written %0d, expected %0d",
                                        result.pixels_written, want.pixels_written));
            end
            results_seen++;
        end
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Sends one request after its idle gap; returns at the accepting edge with
    // the expectation queued. start stays high only if the next request follows
    // back to back, so it is never lowered and raised in the same step.
    task automatic send_request(input crf_req_t r, input bit typed, input crf_result_t want);
        crf_result_t predicted;
        if (pending_gap > 0)
            repeat (pending_gap) @(posedge clk);
        if (!start_held)
            start <= 1'b1;
        start_held = 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        // Accepted at this edge: the predictor runs even when the answer is
        // typed in, so the shadow store follows every fill.
        predicted = model_request(r);
        pending_results.push_back(typed ? want : predicted);
        pending_gap = no_idle ? 0 : $urandom_range(0, 16);
        if (pending_gap != 0)
        begin
            start <= 1'b0;
            start_held = 1'b0;
        end
    endtask

    // Drops start and waits until every answer is in and the block is idle.
    task automatic wait_block_idle();
        if (start_held)
        begin
            start <= 1'b0;
            start_held = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // One register write; cfg_valid is lowered only after the last of a batch.
    task automatic write_screen_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [SCREEN_W-1:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SCREEN_WIDTH:  scr_w = val;
            CFG_SCREEN_HEIGHT: scr_h = val;
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table helpers.
    // ------------------------------------------------------------------
    function automatic crf_req_t mk_fill(input int x, input int y, input int w, input int h,
                                         input int cx0, input int cx1, input int cy0,
                                         input int cy1, input logic [31:0] color,
                                         input logic border);
        crf_req_t r;
        r.req_type      = REQ_FILL;
        r.border_enable = border;
        r.x_pos         = COORD_W'(x);
        r.y_pos         = COORD_W'(y);
        r.rect_width    = COORD_W'(w);
        r.rect_height   = COORD_W'(h);
        r.clip_x_min    = COORD_W'(cx0);
        r.clip_x_max    = COORD_W'(cx1);
        r.clip_y_min    = COORD_W'(cy0);
        r.clip_y_max    = COORD_W'(cy1);
        r.fill_color    = color;
        return r;
    endfunction

    function automatic crf_req_t mk_read(input int x, input int y);
        crf_req_t r;
        r          = '0;
        r.req_type = REQ_READ;
        r.x_pos    = COORD_W'(x);
        r.y_pos    = COORD_W'(y);
        return r;
    endfunction

    // typed = 1 pins the answer to the given color and count.
    task automatic add_req(input crf_req_t r, input bit typed,
                           input logic [31:0] color, input int count);
        stim_row_t row;
        row                     = '0;
        row.kind                = ROW_REQ;
        row.typed               = typed;
        row.rq                  = r;
        row.want.read_color     = color;
        row.want.pixels_written = COUNT_W'(count);
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_value = SCREEN_W'(val);
        stim_rows.push_back(row);
    endtask

    task automatic build_directed_table();
        // Full-screen clear first: the store is garbage until written, and
        // after this every pixel may be read.
        add_req(mk_fill(0, 0, 256, 256, 0, 256, 0, 256, 32'h0000_0000, 1'b0), 1, 0, 65536);
        add_req(mk_read(0, 0), 1, 32'h0, 0);
        add_req(mk_read(255, 255), 1, 32'h0, 0);
        // Reads outside the screen answer zero.
        add_req(mk_read(4095, 4095), 1, 32'h0, 0);
        add_req(mk_read(256, 0), 1, 32'h0, 0);
        // Oversized rectangle and window, both cut to the screen.
        add_req(mk_fill(0, 0, 4095, 4095, 0, 4095, 0, 4095, 32'hffff_ffff, 1'b0),
                1, 0, 65536);
        add_req(mk_read(128, 77), 1, 32'hffff_ffff, 0);
        // Full screen with border: last column and last row gray.
        add_req(mk_fill(0, 0, 4095, 4095, 0, 4095, 0, 4095, 32'h1234_5678, 1'b1),
                1, 0, 65536);
        add_req(mk_read(255, 10), 1, BORDER_GRAY, 0);
        add_req(mk_read(10, 255), 1, BORDER_GRAY, 0);
        add_req(mk_read(254, 254), 1, 32'h1234_5678, 0);
        // Empty results: off screen, inverted window, zero width.
        add_req(mk_fill(4095, 4095, 4095, 4095, 0, 4095, 0, 4095, 32'haaaa_aaaa, 1'b1),
                1, 0, 0);
        add_req(mk_fill(40, 40, 30, 30, 100, 50, 0, 4095, 32'h5555_5555, 1'b0), 1, 0, 0);
        add_req(mk_fill(40, 40, 0, 30, 0, 4095, 0, 4095, 32'h5555_5555, 1'b0), 1, 0, 0);
        // Small bordered box and its corners.
        add_req(mk_fill(10, 20, 5, 3, 0, 4095, 0, 4095, 32'hc0ff_ee01, 1'b1), 1, 0, 15);
        add_req(mk_read(14, 21), 0, 0, 0);
        add_req(mk_read(11, 22), 0, 0, 0);
        add_req(mk_read(10, 20), 0, 0, 0);
        // Rectangle cut on all four sides by the window.
        add_req(mk_fill(0, 0, 100, 100, 30, 40, 50, 55, 32'ha5a5_a5a5, 1'b1), 0, 0, 0);
        add_req(mk_read(39, 52), 0, 0, 0);
        // Single pixel with border is all border.
        add_req(mk_fill(200, 200, 1, 1, 0, 4095, 0, 4095, 32'h0f0f_0f0f, 1'b1), 1, 0, 1);
        add_req(mk_read(200, 200), 1, BORDER_GRAY, 0);
        // Zero-width screen: nothing written, reads answer zero.
        add_cfg(CFG_SCREEN_WIDTH, 0);
        add_cfg(CFG_SCREEN_HEIGHT, 256);
        add_req(mk_fill(0, 0, 50, 50, 0, 4095, 0, 4095, 32'h7777_7777, 1'b0), 1, 0, 0);
        add_req(mk_read(0, 0), 1, 32'h0, 0);
        // Sizes above the store saturate to the store size.
        add_cfg(CFG_SCREEN_WIDTH, 511);
        add_cfg(CFG_SCREEN_HEIGHT, 511);
        add_req(mk_fill(250, 250, 4095, 4095, 0, 4095, 0, 4095, 32'h8765_4321, 1'b0),
                0, 0, 0);
        add_req(mk_read(255, 255), 0, 0, 0);
        // Write to an index with no register behind it.
        add_cfg(CFG_SPARE, 9'h1ff);
        add_req(mk_read(3, 3), 0, 0, 0);
    endtask

    // Random request shaped by the current screen size.
    function automatic crf_req_t make_random_request();
        crf_req_t    r;
        int unsigned aw, ah, pick;
        aw = lim(32'(scr_w), STORE_W);
        ah = lim(32'(scr_h), STORE_H);
        r.border_enable = 1'($urandom_range(0, 1));
        r.x_pos         = rand12();
        r.y_pos         = rand12();
        r.rect_width    = rand12();
        r.rect_height   = rand12();
        r.clip_x_min    = rand12();
        r.clip_x_max    = rand12();
        r.clip_y_min    = rand12();
        r.clip_y_max    = rand12();
        r.fill_color    = $urandom();
        r.req_type      = ($urandom_range(0, 9) < 4) ? REQ_READ : REQ_FILL;
        if (r.req_type == REQ_READ)
        begin
            // Mostly on screen; the rest is noise in every field.
            if ($urandom_range(0, 4) != 0 && aw > 0 && ah > 0)
            begin
                r.x_pos = COORD_W'($urandom_range(0, aw - 1));
                r.y_pos = COORD_W'($urandom_range(0, ah - 1));
            end
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick == 0)
            begin
                // Rare large fill.
                r.x_pos       = COORD_W'($urandom_range(0, 32));
                r.y_pos       = COORD_W'($urandom_range(0, 32));
                r.rect_width  = COORD_W'($urandom_range(128, 300));
                r.rect_height = COORD_W'($urandom_range(128, 300));
                r.clip_x_min  = '0;
                r.clip_y_min  = '0;
                r.clip_x_max  = '1;
                r.clip_y_max  = '1;
            end
            else if (pick >= 15)
            begin
                // Small rectangle near or on the screen, window around it.
                r.x_pos       = COORD_W'($urandom_range(0, aw + 3));
                r.y_pos       = COORD_W'($urandom_range(0, ah + 3));
                r.rect_width  = COORD_W'($urandom_range(0, 24));
                r.rect_height = COORD_W'($urandom_range(0, 24));
                r.clip_x_min  = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, aw)) : '0;
                r.clip_y_min  = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, ah)) : '0;
                case ($urandom_range(0, 3))
                    0: r.clip_x_max = COORD_W'($urandom_range(0, aw + 8));
                    1: r.clip_x_max = COORD_W'($urandom_range(aw, 4095));
                    default: r.clip_x_max = '1;
                endcase
                case ($urandom_range(0, 3))
                    0: r.clip_y_max = COORD_W'($urandom_range(0, ah + 8));
                    1: r.clip_y_max = COORD_W'($urandom_range(ah, 4095));
                    default: r.clip_y_max = '1;
                endcase
            end
            // Otherwise every field stays fully random.
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase_w [PHASES];
        int unsigned phase_h [PHASES];
        bit          in_cfg;
        bit          last;
        int unsigned w, h;

        phase_w = '{256, 1, 0, 511, 300, RANDOM_SIZE, 256, 8, 256, RANDOM_SIZE};
        phase_h = '{256, 1, 256, 0, 511, RANDOM_SIZE, 17, 256, 255, RANDOM_SIZE};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        build_directed_table();
        in_cfg = 1'b0;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                if (!in_cfg)
                    wait_block_idle();
                in_cfg = 1'b1;
                last = (i + 1 == stim_rows.size()) || (stim_rows[i + 1].kind != ROW_CFG);
                write_screen_reg(stim_rows[i].reg_index, stim_rows[i].reg_value, last);
            end
            else
            begin
                in_cfg = 1'b0;
                send_request(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // Random part, one screen setting per phase, some phases back to back.
        for (int p = 0; p < PHASES; p++)
        begin
            w = (phase_w[p] == RANDOM_SIZE) ? $urandom_range(0, 511) : phase_w[p];
            h = (phase_h[p] == RANDOM_SIZE) ? $urandom_range(0, 511) : phase_h[p];
            wait_block_idle();
            write_screen_reg(CFG_SCREEN_WIDTH, SCREEN_W'(w), 1'b0);
            write_screen_reg(CFG_SCREEN_HEIGHT, SCREEN_W'(h), 1'b1);
            no_idle = ($urandom_range(0, 2) == 0);
            if (no_idle)
                pending_gap = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(make_random_request(), 1'b0, '0);
        end

        // Drain, then give the block time to show anything extra.
        wait_block_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* clipped_rectangle_fill_top.f */
src/crf_pkg.sv
src/crf_ram.sv
src/crf_ctrl.sv
src/crf_datapath.sv
src/clipped_rectangle_fill_top.sv
sim/clipped_rectangle_fill_top_tb.sv
